### src/sbm_pkg.sv
// Shared types and constants for the spectrum bar peak-hold meter.
// Used by sbm_alu, sbm_store and the top level; depends on nothing else.
`timescale 1ns / 1ps

package sbm_pkg;

   localparam int NUM_BARS   = 32;
   localparam int BAR_AW     = (NUM_BARS > 1) ? $clog2(NUM_BARS) : 1;
   localparam int BAR_W      = 6;
   localparam int LVL_W      = 16;
   localparam int HOLD_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RISE_FRACTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_STEP  = 2'd3;

   localparam logic [LVL_W-1:0]  RISE_FRACTION_RESET = 16'd32768;
   localparam logic [LVL_W-1:0]  DECAY_STEP_RESET    = 16'd1311;
   localparam logic [HOLD_W-1:0] HOLD_TICKS_RESET    = 8'd20;
   localparam logic [LVL_W-1:0]  GRAVITY_STEP_RESET  = 16'd131;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef enum logic [1:0] {
      ALU_SUB_FLR,
      ALU_MUL_HI,
      ALU_ADD_SAT,
      ALU_MAX
   } alu_op_type;

   typedef struct packed {
      logic [LVL_W-1:0]  height;
      logic [LVL_W-1:0]  cap;
      logic [LVL_W-1:0]  speed;
      logic [HOLD_W-1:0] hold;
   } bar_state_type;

   typedef struct packed {
      logic [BAR_AW-1:0] addr;
      logic              fm_we;
      logic [LVL_W-1:0]  fm_wdata;
      logic              fm_clr;
      logic              bs_we;
      bar_state_type     bs_wdata;
   } store_ctrl_type;

endpackage

### src/sbm_alu.sv
// Shared arithmetic unit of the meter: floored subtract, Q0.16 multiply,
// saturating add and maximum on 16-bit levels. Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_alu (
   input  sbm_pkg::alu_op_type         op,
   input  logic [sbm_pkg::LVL_W-1:0]   a,
   input  logic [sbm_pkg::LVL_W-1:0]   b,
   output logic [sbm_pkg::LVL_W-1:0]   result,
   output logic                        a_gt_b
);
   import sbm_pkg::*;

   logic [2*LVL_W-1:0] product;
   logic [LVL_W:0]     sum;

   assign a_gt_b  = (a > b);
   assign product = a * b;
   assign sum     = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (op)
         ALU_SUB_FLR: result = a_gt_b ? (a - b) : '0;
         ALU_MUL_HI:  result = product[2*LVL_W-1:LVL_W];
         ALU_ADD_SAT: result = sum[LVL_W] ? {LVL_W{1'b1}} : sum[LVL_W-1:0];
         ALU_MAX:     result = a_gt_b ? a : b;
         default:     result = a;
      endcase
   end

endmodule

### src/sbm_store.sv
// Per-bar storage: frame maxima and bar state (height, cap, speed, hold),
// each a memory with registered read and per-entry valid bits. Depends on sbm_pkg.
`timescale 1ns / 1ps

module sbm_store (
   input  logic                           clock,
   input  logic                           reset,
   input  sbm_pkg::store_ctrl_type        ctrl,
   output logic [sbm_pkg::LVL_W-1:0]      fm_rdata,
   output sbm_pkg::bar_state_type         bs_rdata
);
   import sbm_pkg::*;

   logic [LVL_W-1:0]    fm_mem [NUM_BARS];
   bar_state_type       bs_mem [NUM_BARS];
   logic [NUM_BARS-1:0] fm_vld_ff;
   logic [NUM_BARS-1:0] bs_vld_ff;
   logic [LVL_W-1:0]    fm_rdata_ff;
   bar_state_type       bs_rdata_ff;

   // An entry that was never written since reset (or since the last frame
   // clear, for the maxima) reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         fm_vld_ff <= '0;
         bs_vld_ff <= '0;
      end else begin
         if (ctrl.fm_clr) begin
            fm_vld_ff <= '0;
         end else if (ctrl.fm_we) begin
            fm_vld_ff[ctrl.addr] <= 1'b1;
         end
         if (ctrl.bs_we) begin
            bs_vld_ff[ctrl.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.fm_we) begin
         fm_mem[ctrl.addr] <= ctrl.fm_wdata;
      end
      if (ctrl.bs_we) begin
         bs_mem[ctrl.addr] <= ctrl.bs_wdata;
      end
   end

   always_ff @(posedge clock) begin
      fm_rdata_ff <= fm_vld_ff[ctrl.addr] ? fm_mem[ctrl.addr] : '0;
      bs_rdata_ff <= bs_vld_ff[ctrl.addr] ? bs_mem[ctrl.addr] : '0;
   end

   assign fm_rdata = fm_rdata_ff;
   assign bs_rdata = bs_rdata_ff;

endmodule

### src/spectrum_bar_peak_hold_meter_unit.sv
// Top level of the spectrum bar meter: sequencer, configuration registers
// and output register. Depends on sbm_pkg, sbm_alu and sbm_store.
// A bin sample passes ST_SAMPLE, which writes its frame maximum; an out-of-range sample
// or an empty tick is taken in ST_IDLE alone. A tick walks each bar in turn through
// ST_LOAD, ST_GAP, ST_MUL, ST_HGT, ST_CMP, ST_VEL, ST_CAP and ST_OUT, using the shared
// arithmetic unit; ST_OUT waits out any output stall. Reset is synchronous and sets the registers
// to their defaults; all stored levels read as zero at once, with no clearing pass.
`timescale 1ns / 1ps

module spectrum_bar_peak_hold_meter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [sbm_pkg::BAR_W-1:0]        req_bar_index,
   input  logic [sbm_pkg::LVL_W-1:0]        req_magnitude,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sbm_pkg::BAR_W-1:0]        rsp_out_bar,
   output logic [sbm_pkg::LVL_W-1:0]        rsp_bar_height,
   output logic [sbm_pkg::LVL_W-1:0]        rsp_peak_position,
   output logic                             rsp_last_bar,
   input  logic                             csr_we,
   input  logic [sbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sbm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_LOAD,
      ST_GAP,
      ST_MUL,
      ST_HGT,
      ST_CMP,
      ST_VEL,
      ST_CAP,
      ST_OUT
   } state_type;

   localparam logic [BAR_AW-1:0] LAST_BAR = BAR_AW'(NUM_BARS - 1);

   logic [LVL_W-1:0]  rise_fraction_ff;
   logic [LVL_W-1:0]  decay_step_ff;
   logic [HOLD_W-1:0] hold_ticks_ff;
   logic [LVL_W-1:0]  gravity_step_ff;

   state_type         state_ff, state_in;
   logic [BAR_AW-1:0] bar_ff, bar_in;
   logic [LVL_W-1:0]  mag_ff, mag_in;
   logic              frame_seen_ff, frame_seen_in;
   logic [LVL_W-1:0]  work_ff, work_in;
   logic [LVL_W-1:0]  height_ff, height_in;
   logic              rise_ff, rise_in;
   logic              fall_ff, fall_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BAR_W-1:0]  rsp_bar_ff, rsp_bar_in;
   logic [LVL_W-1:0]  rsp_height_ff, rsp_height_in;
   logic [LVL_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic              rsp_last_ff, rsp_last_in;

   alu_op_type        alu_op;
   logic [LVL_W-1:0]  alu_a;
   logic [LVL_W-1:0]  alu_b;
   logic [LVL_W-1:0]  alu_result;
   logic              alu_gt;

   store_ctrl_type    store_ctrl;
   logic [LVL_W-1:0]  fm_rdata;
   bar_state_type     bs_rdata;
   bar_state_type     bs_next;
   logic              req_accept;
   logic              in_range;

   sbm_alu u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .a_gt_b (alu_gt)
   );

   sbm_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (store_ctrl),
      .fm_rdata (fm_rdata),
      .bs_rdata (bs_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_fraction_ff <= RISE_FRACTION_RESET;
         decay_step_ff    <= DECAY_STEP_RESET;
         hold_ticks_ff    <= HOLD_TICKS_RESET;
         gravity_step_ff  <= GRAVITY_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RISE_FRACTION: rise_fraction_ff <= csr_wdata;
            CSR_DECAY_STEP:    decay_step_ff    <= csr_wdata;
            CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_wdata[HOLD_W-1:0];
            CSR_GRAVITY_STEP:  gravity_step_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign in_range   = ({1'b0, req_bar_index} < (BAR_W + 1)'(NUM_BARS));

   always_comb begin
      state_in      = state_ff;
      bar_in        = bar_ff;
      mag_in        = mag_ff;
      frame_seen_in = frame_seen_ff;
      work_in       = work_ff;
      height_in     = height_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_bar_in    = rsp_bar_ff;
      rsp_height_in = rsp_height_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_last_in   = rsp_last_ff;

      alu_op = ALU_MAX;
      alu_a  = mag_ff;
      alu_b  = fm_rdata;

      bs_next = bs_rdata;

      store_ctrl          = '0;
      store_ctrl.addr     = bar_ff;
      store_ctrl.fm_wdata = alu_result;
      store_ctrl.bs_wdata = bs_next;

      case (state_ff)
         ST_IDLE: begin
            store_ctrl.addr = req_bar_index[BAR_AW-1:0];
            if (req_accept) begin
               if (req_type == REQ_SAMPLE) begin
                  if (in_range) begin
                     bar_in        = req_bar_index[BAR_AW-1:0];
                     mag_in        = req_magnitude;
                     frame_seen_in = 1'b1;
                     state_in      = ST_SAMPLE;
                  end
               end else if (frame_seen_ff) begin
                  bar_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_SAMPLE: begin
            store_ctrl.fm_we = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_LOAD: begin
            state_in = ST_GAP;
         end
         ST_GAP: begin
            alu_op   = ALU_SUB_FLR;
            alu_a    = fm_rdata;
            alu_b    = bs_rdata.height;
            work_in  = alu_result;
            rise_in  = alu_gt;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            alu_op   = ALU_MUL_HI;
            alu_a    = work_ff;
            alu_b    = rise_fraction_ff;
            work_in  = alu_result;
            state_in = ST_HGT;
         end
         ST_HGT: begin
            alu_op    = rise_ff ? ALU_ADD_SAT : ALU_SUB_FLR;
            alu_a     = bs_rdata.height;
            alu_b     = rise_ff ? work_ff : decay_step_ff;
            height_in = alu_result;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            alu_op   = ALU_SUB_FLR;
            alu_a    = bs_rdata.cap;
            alu_b    = height_ff;
            fall_in  = alu_gt;
            state_in = ST_VEL;
         end
         ST_VEL: begin
            alu_op   = ALU_ADD_SAT;
            alu_a    = bs_rdata.speed;
            alu_b    = gravity_step_ff;
            work_in  = alu_result;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            alu_op         = ALU_SUB_FLR;
            alu_a          = bs_rdata.cap;
            alu_b          = work_ff;
            bs_next.height = height_ff;
            if (!fall_ff) begin
               bs_next.cap   = height_ff;
               bs_next.speed = '0;
               bs_next.hold  = hold_ticks_ff;
            end else if (bs_rdata.hold != '0) begin
               bs_next.hold = bs_rdata.hold - 1'b1;
            end else begin
               bs_next.speed = work_ff;
               bs_next.cap   = alu_result;
            end
            store_ctrl.bs_we    = 1'b1;
            store_ctrl.bs_wdata = bs_next;
            rsp_valid_in  = 1'b1;
            rsp_bar_in    = BAR_W'(bar_ff);
            rsp_height_in = bs_next.height;
            rsp_peak_in   = bs_next.cap;
            rsp_last_in   = (bar_ff == LAST_BAR);
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (bar_ff == LAST_BAR) begin
                  store_ctrl.fm_clr = 1'b1;
                  frame_seen_in     = 1'b0;
                  state_in          = ST_IDLE;
               end else begin
                  bar_in   = bar_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frame_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_seen_ff <= frame_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      bar_ff        <= bar_in;
      mag_ff        <= mag_in;
      work_ff       <= work_in;
      height_ff     <= height_in;
      rise_ff       <= rise_in;
      fall_ff       <= fall_in;
      rsp_bar_ff    <= rsp_bar_in;
      rsp_height_ff <= rsp_height_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_bar       = rsp_bar_ff;
   assign rsp_bar_height    = rsp_height_ff;
   assign rsp_peak_position = rsp_peak_ff;
   assign rsp_last_bar      = rsp_last_ff;

endmodule

### verif/spectrum_bar_peak_hold_meter_unit_test.sv
// Self-checking testbench for spectrum_bar_peak_hold_meter_unit: drives bin samples and
// frame ticks, predicts every bar result, and checks each word as it leaves.
// Depends on sbm_pkg and the block's RTL only.
`timescale 1ns / 1ps

import sbm_pkg::*;

typedef struct packed {
   logic [BAR_W-1:0] bar;
   logic [LVL_W-1:0] height;
   logic [LVL_W-1:0] cap;
   logic             last;
} bar_level_type;

class meter_scoreboard;
   logic [LVL_W-1:0]  rise_fraction;
   logic [LVL_W-1:0]  decay_step;
   logic [HOLD_W-1:0] hold_ticks;
   logic [LVL_W-1:0]  gravity_step;
   logic [LVL_W-1:0]  frame_peak [NUM_BARS];
   logic [LVL_W-1:0]  height [NUM_BARS];
   logic [LVL_W-1:0]  cap [NUM_BARS];
   logic [LVL_W-1:0]  speed [NUM_BARS];
   logic [HOLD_W-1:0] hold_left [NUM_BARS];
   bit                frame_live;
   bar_level_type     due_levels [$];
   int                mismatches;

   function new();
      rise_fraction = RISE_FRACTION_RESET;
      decay_step    = DECAY_STEP_RESET;
      hold_ticks    = HOLD_TICKS_RESET;
      gravity_step  = GRAVITY_STEP_RESET;
      foreach (height[b]) begin
         frame_peak[b] = '0;
         height[b]     = '0;
         cap[b]        = '0;
         speed[b]      = '0;
         hold_left[b]  = '0;
      end
      frame_live = 1'b0;
      mismatches = 0;
   endfunction

   function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_RISE_FRACTION: rise_fraction = value[LVL_W-1:0];
         CSR_DECAY_STEP:    decay_step    = value[LVL_W-1:0];
         CSR_HOLD_TICKS:    hold_ticks    = value[HOLD_W-1:0];
         CSR_GRAVITY_STEP:  gravity_step  = value[LVL_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return due_levels.size();
   endfunction

   // One frame tick moves every bar and queues its level word.
   function void advance_bars();
      logic [31:0]   m, h, p, v, c;
      bar_level_type lvl;
      for (int b = 0; b < NUM_BARS; b++) begin
         m = frame_peak[b];
         h = height[b];
         p = cap[b];
         v = speed[b];
         c = hold_left[b];
         if (m > h)
            h = h + (((m - h) * rise_fraction) >> 16);
         else
            h = (h > decay_step) ? h - decay_step : 32'd0;
         if (h >= p) begin
            p = h;
            v = 32'd0;
            c = hold_ticks;
         end else if (c > 0) begin
            c = c - 1;
         end else begin
            v = v + gravity_step;
            if (v > 32'hFFFF)
               v = 32'hFFFF;
            p = (p > v) ? p - v : 32'd0;
         end
         height[b]     = h[LVL_W-1:0];
         cap[b]        = p[LVL_W-1:0];
         speed[b]      = v[LVL_W-1:0];
         hold_left[b]  = c[HOLD_W-1:0];
         frame_peak[b] = '0;
         lvl.bar    = BAR_W'(b);
         lvl.height = height[b];
         lvl.cap    = cap[b];
         lvl.last   = (b == NUM_BARS - 1);
         due_levels.push_back(lvl);
      end
      frame_live = 1'b0;
   endfunction

   function void note_word(input logic kind, input logic [BAR_W-1:0] bar,
                           input logic [LVL_W-1:0] mag);
      if (kind == REQ_SAMPLE) begin
         if (bar < NUM_BARS) begin
            if (mag > frame_peak[bar])
               frame_peak[bar] = mag;
            frame_live = 1'b1;
         end
      end else if (frame_live) begin
         advance_bars();
      end
   endfunction

   function void complain(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
   endfunction

   function void check_word(input bar_level_type got);
      bar_level_type want;
      if (due_levels.size() == 0) begin
         complain("result word with none pending, out_bar", 0, got.bar);
         return;
      end
      want = due_levels.pop_front();
      if (got.bar !== want.bar)
         complain("out_bar", want.bar, got.bar);
      if (got.height !== want.height)
         complain($sformatf("bar_height of bar %0d", want.bar), want.height, got.height);
      if (got.cap !== want.cap)
         complain($sformatf("peak_position of bar %0d", want.bar), want.cap, got.cap);
      if (got.last !== want.last)
         complain($sformatf("last_bar of bar %0d", want.bar), want.last, got.last);
   endfunction
endclass

module spectrum_bar_peak_hold_meter_unit_test;
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = REQ_SAMPLE;
   logic [BAR_W-1:0]      req_bar_index = '0;
   logic [LVL_W-1:0]      req_magnitude = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BAR_W-1:0]      rsp_out_bar;
   logic [LVL_W-1:0]      rsp_bar_height;
   logic [LVL_W-1:0]      rsp_peak_position;
   logic                  rsp_last_bar;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bit              calm = 1'b0;
   int              stall_left = 0;
   int              words_sent = 0;
   meter_scoreboard board = new();

   spectrum_bar_peak_hold_meter_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 15);
      if (roll < 8)
         return 0;
      if (roll < 15)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(bar_level_type'({rsp_out_bar, rsp_bar_height,
                                           rsp_peak_position, rsp_last_bar}));
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap();
      end
   end

   task automatic send_word(input logic kind, input logic [BAR_W-1:0] bar,
                            input logic [LVL_W-1:0] mag);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_bar_index <= bar;
      req_magnitude <= mag;
      do @(posedge clock); while (req_stall);
      board.note_word(kind, bar, mag);
      words_sent++;
   endtask

   task automatic send_random_frame();
      int               count;
      logic [BAR_W-1:0] bar;
      logic [LVL_W-1:0] mag;
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 6);
      repeat (count) begin
         if ($urandom_range(0, 7) == 0)
            bar = BAR_W'($urandom_range(NUM_BARS, 63));
         else
            bar = BAR_W'($urandom_range(0, NUM_BARS - 1));
         case ($urandom_range(0, 7))
            0:       mag = '1;
            1:       mag = LVL_W'($urandom_range(0, 255));
            default: mag = LVL_W'($urandom);
         endcase
         send_word(REQ_SAMPLE, bar, mag);
      end
      send_word(REQ_TICK, BAR_W'($urandom), LVL_W'($urandom));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic run_phase(input int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at)
         send_random_frame();
      drain();
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic write_config(input logic [CSR_DATA_W-1:0] rise, input logic [CSR_DATA_W-1:0] decay,
                               input logic [CSR_DATA_W-1:0] hold, input logic [CSR_DATA_W-1:0] grav);
      put_reg(CSR_RISE_FRACTION, rise);
      put_reg(CSR_DECAY_STEP, decay);
      put_reg(CSR_HOLD_TICKS, hold);
      put_reg(CSR_GRAVITY_STEP, grav);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty frames, out-of-range bars and full-scale words under reset settings.
      send_word(REQ_TICK, '0, '0);
      send_word(REQ_SAMPLE, 6'd63, 16'hFFFF);
      send_word(REQ_SAMPLE, 6'd32, 16'h0001);
      send_word(REQ_TICK, 6'd63, 16'hFFFF);
      send_word(REQ_SAMPLE, 6'd0, 16'hFFFF);
      send_word(REQ_SAMPLE, 6'd31, 16'hFFFF);
      send_word(REQ_SAMPLE, 6'd0, 16'h0000);
      send_word(REQ_SAMPLE, 6'd31, 16'h1234);
      send_word(REQ_SAMPLE, 6'd10, 16'hAAAA);
      send_word(REQ_SAMPLE, 6'd21, 16'h5555);
      send_word(REQ_SAMPLE, 6'd42, 16'h5555);
      send_word(REQ_TICK, 6'd21, 16'h0000);
      send_word(REQ_TICK, 6'd0, 16'h0000);
      send_word(REQ_SAMPLE, 6'd5, 16'h0000);
      send_word(REQ_TICK, 6'd5, 16'hFFFF);
      run_phase(60);

      write_config(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      calm = 1'b1;
      run_phase(55);
      calm = 1'b0;

      // With a zero rise fraction a full-scale word must leave the height alone.
      write_config(16'h0000, 16'h0000, 16'h00FF, 16'h0000);
      send_word(REQ_SAMPLE, 6'd3, 16'hFFFF);
      send_word(REQ_TICK, 6'd3, 16'hFFFF);
      run_phase(50);

      write_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom_range(0, 4000)),
                   CSR_DATA_W'($urandom_range(0, 4)), CSR_DATA_W'($urandom_range(0, 4000)));
      run_phase(60);

      write_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      run_phase(60);

      if (board.mismatches == 0 && board.pending() == 0)
         $display("spectrum_bar_peak_hold_meter_unit test passed");
      else
         $display("spectrum_bar_peak_hold_meter_unit test failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("spectrum_bar_peak_hold_meter_unit test failed");
      $finish;
   end
endmodule

### files.f
src/sbm_pkg.sv
src/sbm_alu.sv
src/sbm_store.sv
src/spectrum_bar_peak_hold_meter_unit.sv
verif/spectrum_bar_peak_hold_meter_unit_test.sv
